// ----- rtl/satc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package satc_pkg;

    localparam int MAX_SAMPLES = 1024;
    localparam int NUM_ALLELES = 6;
    localparam int CNT_W       = 12;

    // Each counter saturates at twice the sample limit, never above the counter range
    localparam int CAP_INT = (2 * MAX_SAMPLES > 4095) ? 4095 : 2 * MAX_SAMPLES;
    localparam logic [CNT_W-1:0] COUNT_CAP = CNT_W'(CAP_INT);

    // Genotype call codes
    localparam logic [3:0] CODE_HOM_LAST   = 4'd5;
    localparam logic [3:0] CODE_PAIR_FIRST = 4'd6;
    localparam logic [3:0] CODE_PAIR_LAST  = 4'd11;
    localparam logic [3:0] CODE_HET_DEL    = 4'd12;
    localparam logic [3:0] CODE_HET_INS    = 4'd13;
    localparam logic [3:0] REF_LAST_BASE   = 4'd3;

    // Allele indexes
    localparam logic [2:0] ALLELE_A    = 3'd0;
    localparam logic [2:0] ALLELE_C    = 3'd1;
    localparam logic [2:0] ALLELE_G    = 3'd2;
    localparam logic [2:0] ALLELE_T    = 3'd3;
    localparam logic [2:0] ALLELE_DEL  = 3'd4;
    localparam logic [2:0] ALLELE_INS  = 3'd5;
    localparam logic [2:0] ALLELE_NONE = 3'd6;

    typedef enum logic [2:0] {
        SITE_NONE  = 3'd0,
        SITE_SNP   = 3'd1,
        SITE_DEL   = 3'd2,
        SITE_INS   = 3'd3,
        SITE_MULTI = 3'd4
    } site_type_t;

    // Configuration space
    localparam int         ADDR_W          = 3;
    localparam logic [0:0] REG_HAPLOID_IDX = 1'b0;

    // Queue depths
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int OUT_DEPTH   = 4;
    localparam int OPTR_W      = 2;

    typedef struct packed {
        logic [3:0] call_code;
        logic [3:0] ref_code;
        logic       site_end;
    } sample_t;

    typedef struct packed {
        logic [CNT_W-1:0] count_a;
        logic [CNT_W-1:0] count_c;
        logic [CNT_W-1:0] count_g;
        logic [CNT_W-1:0] count_t;
        logic [CNT_W-1:0] count_del;
        logic [CNT_W-1:0] count_ins;
        logic [2:0]       allele_kinds;
        logic [2:0]       site_type;
        logic             reported;
    } result_t;

    typedef logic [1:0] inc_t;

    // One decoded call: per-allele increment of zero, one or two, plus site end
    typedef struct packed {
        inc_t [NUM_ALLELES-1:0] inc;
        logic                   last;
    } tally_t;

    // Heterozygous base pairs, indexed by code minus the first pair code
    function automatic logic [2:0] pair_first(input logic [2:0] idx);
        logic [2:0] a;
        case (idx)
            3'd0:    a = ALLELE_A;
            3'd1:    a = ALLELE_A;
            3'd2:    a = ALLELE_A;
            3'd3:    a = ALLELE_C;
            3'd4:    a = ALLELE_C;
            3'd5:    a = ALLELE_G;
            default: a = ALLELE_NONE;
        endcase
        return a;
    endfunction

    function automatic logic [2:0] pair_second(input logic [2:0] idx);
        logic [2:0] a;
        case (idx)
            3'd0:    a = ALLELE_C;
            3'd1:    a = ALLELE_G;
            3'd2:    a = ALLELE_T;
            3'd3:    a = ALLELE_G;
            3'd4:    a = ALLELE_T;
            3'd5:    a = ALLELE_T;
            default: a = ALLELE_NONE;
        endcase
        return a;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/satc_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module satc_front
(
    input  var satc_pkg::sample_t sample,
    input  wire                   haploid,
    output satc_pkg::tally_t      tally
);

    logic [2:0] x;
    logic [2:0] y;
    logic [2:0] ref_allele;
    logic [2:0] pair_idx;

    always_comb
    begin
        ref_allele = (sample.ref_code <= satc_pkg::REF_LAST_BASE) ?
                     sample.ref_code[2:0] : satc_pkg::ALLELE_NONE;
        pair_idx   = 3'(sample.call_code - satc_pkg::CODE_PAIR_FIRST);

        if (sample.call_code <= satc_pkg::CODE_HOM_LAST)
        begin
            x = sample.call_code[2:0];
            y = sample.call_code[2:0];
        end
        else if (sample.call_code <= satc_pkg::CODE_PAIR_LAST)
        begin
            x = satc_pkg::pair_first(pair_idx);
            y = satc_pkg::pair_second(pair_idx);
        end
        else if (sample.call_code == satc_pkg::CODE_HET_DEL)
        begin
            x = ref_allele;
            y = satc_pkg::ALLELE_DEL;
        end
        else if (sample.call_code == satc_pkg::CODE_HET_INS)
        begin
            x = ref_allele;
            y = satc_pkg::ALLELE_INS;
        end
        else
        begin
            x = satc_pkg::ALLELE_NONE;
            y = satc_pkg::ALLELE_NONE;
        end
    end

    // Drop the second allele in haploid mode
    always_comb
    begin
        for (int k = 0; k < satc_pkg::NUM_ALLELES; k++)
        begin
            tally.inc[k] = 2'(x == 3'(k)) + 2'(!haploid && (y == 3'(k)));
        end
        tally.last = sample.site_end;
    end

endmodule

`default_nettype wire

// ----- rtl/satc_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

module satc_queue
(
    input  wire              clk,
    input  wire              rst_n,
    input  wire              wr_en,
    input  var satc_pkg::tally_t wr_data,
    output logic             full,
    input  wire              rd_en,
    output logic             valid,
    output satc_pkg::tally_t head
);

    satc_pkg::tally_t                slot_reg [satc_pkg::QUEUE_DEPTH];
    logic [satc_pkg::QPTR_W-1:0]     wr_ptr_reg;
    logic [satc_pkg::QPTR_W-1:0]     wr_ptr_next;
    logic [satc_pkg::QPTR_W-1:0]     rd_ptr_reg;
    logic [satc_pkg::QPTR_W-1:0]     rd_ptr_next;
    logic [satc_pkg::QPTR_W:0]       count_reg;
    logic [satc_pkg::QPTR_W:0]       count_next;

    assign full  = (count_reg == (satc_pkg::QPTR_W + 1)'(satc_pkg::QUEUE_DEPTH));
    assign valid = (count_reg != '0);
    assign head  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_en ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = rd_en ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (satc_pkg::QPTR_W + 1)'(wr_en)
                      - (satc_pkg::QPTR_W + 1)'(rd_en);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/satc_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module satc_back
(
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  q_valid,
    input  var satc_pkg::tally_t q_head,
    output logic                 q_pop,
    input  wire                  pop,
    output logic                 empty,
    output satc_pkg::result_t    result
);

    localparam int CW = satc_pkg::CNT_W;
    localparam int NA = satc_pkg::NUM_ALLELES;

    logic [CW-1:0]               cnt_reg  [NA];
    logic [CW-1:0]               cnt_next [NA];
    logic [CW-1:0]               upd      [NA];
    logic [CW:0]                 sum      [NA];
    logic [CW-1:0]               snap_reg [NA];
    logic                        snap_valid_reg;
    logic                        snap_valid_next;
    logic                        room;
    logic                        take_last;

    satc_pkg::result_t           fin;
    logic [2:0]                  kinds;
    satc_pkg::site_type_t        stype;

    satc_pkg::result_t           out_slot_reg [satc_pkg::OUT_DEPTH];
    logic [satc_pkg::OPTR_W-1:0] out_wr_reg;
    logic [satc_pkg::OPTR_W-1:0] out_rd_reg;
    logic [satc_pkg::OPTR_W:0]   out_count_reg;
    logic [satc_pkg::OPTR_W:0]   out_count_next;
    logic                        out_rd;

    // Reserve an output slot for every site end in flight
    assign room = ((satc_pkg::OPTR_W + 2)'(out_count_reg) + (satc_pkg::OPTR_W + 2)'(snap_valid_reg))
                  < (satc_pkg::OPTR_W + 2)'(satc_pkg::OUT_DEPTH);
    assign q_pop     = q_valid && (!q_head.last || room);
    assign take_last = q_pop && q_head.last;

    always_comb
    begin
        for (int k = 0; k < NA; k++)
        begin
            sum[k] = {1'b0, cnt_reg[k]} + (CW + 1)'(q_head.inc[k]);
            upd[k] = (sum[k] > {1'b0, satc_pkg::COUNT_CAP}) ? satc_pkg::COUNT_CAP
                                                             : sum[k][CW-1:0];
            if (q_pop)
                cnt_next[k] = q_head.last ? '0 : upd[k];
            else
                cnt_next[k] = cnt_reg[k];
        end
        snap_valid_next = take_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NA; k++)
            begin
                cnt_reg[k] <= '0;
            end
            snap_valid_reg <= 1'b0;
        end
        else
        begin
            for (int k = 0; k < NA; k++)
            begin
                cnt_reg[k] <= cnt_next[k];
            end
            snap_valid_reg <= snap_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_last)
        begin
            for (int k = 0; k < NA; k++)
            begin
                snap_reg[k] <= upd[k];
            end
        end
    end

    // Classify the captured site
    always_comb
    begin
        kinds = '0;
        for (int k = 0; k < NA; k++)
        begin
            kinds = kinds + 3'(snap_reg[k] != '0);
        end

        if (kinds == '0)
            stype = satc_pkg::SITE_NONE;
        else if (kinds > 3'd2)
            stype = satc_pkg::SITE_MULTI;
        else if (snap_reg[satc_pkg::ALLELE_DEL] != '0)
            stype = satc_pkg::SITE_DEL;
        else if (snap_reg[satc_pkg::ALLELE_INS] != '0)
            stype = satc_pkg::SITE_INS;
        else
            stype = satc_pkg::SITE_SNP;

        fin.count_a      = snap_reg[satc_pkg::ALLELE_A];
        fin.count_c      = snap_reg[satc_pkg::ALLELE_C];
        fin.count_g      = snap_reg[satc_pkg::ALLELE_G];
        fin.count_t      = snap_reg[satc_pkg::ALLELE_T];
        fin.count_del    = snap_reg[satc_pkg::ALLELE_DEL];
        fin.count_ins    = snap_reg[satc_pkg::ALLELE_INS];
        fin.allele_kinds = kinds;
        fin.site_type    = stype;
        fin.reported     = (kinds != '0);
    end

    // Output buffer
    assign empty  = (out_count_reg == '0);
    assign out_rd = pop && !empty;
    assign result = out_slot_reg[out_rd_reg];

    assign out_count_next = out_count_reg + (satc_pkg::OPTR_W + 1)'(snap_valid_reg)
                            - (satc_pkg::OPTR_W + 1)'(out_rd);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_wr_reg    <= '0;
            out_rd_reg    <= '0;
            out_count_reg <= '0;
        end
        else
        begin
            if (snap_valid_reg)
                out_wr_reg <= out_wr_reg + 1'b1;
            if (out_rd)
                out_rd_reg <= out_rd_reg + 1'b1;
            out_count_reg <= out_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (snap_valid_reg)
        begin
            out_slot_reg[out_wr_reg] <= fin;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/site_allele_tally_classifier_top.sv -----
// A word accepted into the decode queue waits there until the counters take it;
// its site result (on the last sample) passes through the counter bank and its
// capture register, then into the output buffer.
// Throughput: one sample word per cycle while the decode queue is not full and the output buffer has room.
// Reset (rst_n, async, active low) clears the counters, both queues and
// haploid_mode; no clearing pass follows.
`timescale 1ns / 1ps
`default_nettype none

module site_allele_tally_classifier_top
(
    input  wire                          clk,
    input  wire                          rst_n,

    // Sample word input
    input  wire                          push,
    output logic                         full,
    input  var satc_pkg::sample_t        sample,

    // Site result output
    output logic                         empty,
    input  wire                          pop,
    output satc_pkg::result_t            result,

    // Configuration port
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire [satc_pkg::ADDR_W-1:0]   paddr,
    input  wire [31:0]                   pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    logic             haploid_reg;
    logic             haploid_next;
    logic             cfg_hit;
    logic             cfg_wr;

    satc_pkg::tally_t tally;
    satc_pkg::tally_t q_head;
    logic             q_full;
    logic             q_valid;
    logic             q_pop;
    logic             in_take;

    // Decode the register index from the word address; only one register exists.
    assign pready  = 1'b1;
    assign cfg_hit = (paddr[satc_pkg::ADDR_W-1:2] == satc_pkg::REG_HAPLOID_IDX);
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign prdata  = cfg_hit ? {31'b0, haploid_reg} : 32'b0;

    // Take bit 0 of a write to haploid_mode, hold otherwise
    assign haploid_next = (cfg_wr && cfg_hit) ? pwdata[0] : haploid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            haploid_reg <= 1'b0;
        else
            haploid_reg <= haploid_next;
    end

    // Front end: classify each call into per-allele increments
    satc_front u_front
    (
        .sample  (sample),
        .haploid (haploid_reg),
        .tally   (tally)
    );

    // Accept a word whenever the decode queue has space
    assign full    = q_full;
    assign in_take = push && !q_full;

    // Decouple decode from counting so each side stalls on its own
    satc_queue u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (in_take),
        .wr_data (tally),
        .full    (q_full),
        .rd_en   (q_pop),
        .valid   (q_valid),
        .head    (q_head)
    );

    // Back end: advance the counters, capture and classify on the site's last
    // sample, then hold results in a small output buffer until popped
    satc_back u_back
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_head  (q_head),
        .q_pop   (q_pop),
        .pop     (pop),
        .empty   (empty),
        .result  (result)
    );

endmodule

`default_nettype wire

// ----- rtl/satc_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module satc_checker
(
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire                        empty,
    input  wire                        pop,
    input  var satc_pkg::result_t      result
);

    // Reported flag follows the allele kinds
    a_reported: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (result.reported == (result.allele_kinds != 3'd0)))
        else $error("reported disagrees with allele_kinds");

    // An empty site carries no counts and no type
    a_empty_site: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.allele_kinds == 3'd0) |->
            (result.site_type == 3'(satc_pkg::SITE_NONE) && result.count_a == '0 &&
             result.count_c == '0 && result.count_g == '0 && result.count_t == '0 &&
             result.count_del == '0 && result.count_ins == '0))
        else $error("empty site with nonzero field");

    // More than two kinds is multiallelic
    a_multi: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.allele_kinds > 3'd2) |->
            (result.site_type == 3'(satc_pkg::SITE_MULTI)))
        else $error("multiallelic site misclassified");

    // Deletion count nonzero with at most two kinds means DEL
    a_del: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.allele_kinds != 3'd0 && result.allele_kinds <= 3'd2 &&
         result.count_del != '0) |-> (result.site_type == 3'(satc_pkg::SITE_DEL)))
        else $error("deletion site misclassified");

    // A waiting word holds until popped
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result)))
        else $error("result word changed while waiting");

endmodule

bind site_allele_tally_classifier_top satc_checker u_satc_checker
(
    .clk    (clk),
    .rst_n  (rst_n),
    .empty  (empty),
    .pop    (pop),
    .result (result)
);

`default_nettype wire
